FILE: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted event priority queue package
// Shared sizes, the event entry type, cell control and result codes.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int NODE_BITS   = 14;

	// Widths fixed by the port list.
	localparam int NODE_PORT_W = 14;
	localparam int PRIO_W      = 16;
	localparam int TIME_W      = 16;
	localparam int OCC_W       = 7;
	localparam int OUTCOME_W   = 2;

	// Only the bits that survive both the entry mask and the port width are kept.
	localparam int STORE_NODE_W = (NODE_BITS < NODE_PORT_W) ? NODE_BITS : NODE_PORT_W;
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	localparam logic [OUTCOME_W-1:0] OUT_DONE      = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUT_POP_EMPTY = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUT_PUSH_FULL = 2'd2;

	typedef struct packed {
		logic [STORE_NODE_W-1:0] node;
		logic [PRIO_W-1:0]       prio;
		logic [TIME_W-1:0]       etime;
		logic                    kind;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

FILE: sv/sorted_event_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted event priority queue
// A row of cells keeps events sorted by ascending priority; pushes insert in
// place and pops take the head.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle: busy is never raised, since every push
// or pop completes in a single shift of the cell row. The result for an item
// is shown, with done high, in the cycle right after the item is accepted, and
// the receiver must take it then. The head fields read zero when the queue is
// empty. A pop on an empty queue or a push on a full one changes nothing and
// is reported through outcome.
module sorted_event_priority_queue import spq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    action,
	input  logic [NODE_PORT_W-1:0]  node_id,
	input  logic [PRIO_W-1:0]       event_priority,
	input  logic [TIME_W-1:0]       event_time,
	input  logic                    event_kind,
	output logic                    done,
	output logic                    head_valid,
	output logic [NODE_PORT_W-1:0]  head_node,
	output logic [PRIO_W-1:0]       head_priority,
	output logic [TIME_W-1:0]       head_time,
	output logic                    head_kind,
	output logic [OCC_W-1:0]        occupancy,
	output logic [OUTCOME_W-1:0]    outcome
);

	logic [CNT_W-1:0]     count_q;
	logic                 done_q;
	logic [OUTCOME_W-1:0] outcome_q;

	logic      accept;
	logic      is_full;
	logic      is_empty;
	cell_ctl_t ctl;
	entry_t    new_entry;

	entry_t cell_entry [QUEUE_DEPTH];
	logic   cell_after [QUEUE_DEPTH];

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);

	assign ctl.push = accept && (action == ACT_PUSH) && !is_full;
	assign ctl.pop  = accept && (action == ACT_POP) && !is_empty;

	assign new_entry.node  = node_id[STORE_NODE_W-1:0];
	assign new_entry.prio  = event_priority;
	assign new_entry.etime = event_time;
	assign new_entry.kind  = event_kind;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_a;

		if (i == 0) begin : g_first
			assign left_e = new_entry;
			assign left_a = 1'b1;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_a = cell_after[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign right_e = cell_entry[i];
		end else begin : g_body
			assign right_e = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (count_q > CNT_W'(i)),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.left_after  (left_a),
			.right_entry (right_e),
			.entry       (cell_entry[i]),
			.after       (cell_after[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			done_q    <= 1'b0;
			outcome_q <= OUT_DONE;
		end else begin
			done_q <= accept;
			if (ctl.push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				priority if ((action == ACT_POP) && is_empty) begin
					outcome_q <= OUT_POP_EMPTY;
				end else if ((action == ACT_PUSH) && is_full) begin
					outcome_q <= OUT_PUSH_FULL;
				end else begin
					outcome_q <= OUT_DONE;
				end
			end
		end
	end

	assign done          = done_q;
	assign head_valid    = !is_empty;
	assign head_node     = is_empty ? '0 : NODE_PORT_W'(cell_entry[0].node);
	assign head_priority = is_empty ? '0 : cell_entry[0].prio;
	assign head_time     = is_empty ? '0 : cell_entry[0].etime;
	assign head_kind     = is_empty ? 1'b0 : cell_entry[0].kind;
	assign occupancy     = OCC_W'(count_q);
	assign outcome       = outcome_q;

endmodule

FILE: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted event priority queue cell
// Holds one event, compares its key with the incoming event and takes its
// own entry, the new event, or a neighbor's entry on each push or pop.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  entry_t    new_entry,
	input  entry_t    left_entry,
	input  logic      left_after,
	input  entry_t    right_entry,
	output entry_t    entry,
	output logic      after
);

	entry_t entry_q;

	assign entry = entry_q;

	// The new event goes behind every held event of equal or lower key.
	assign after = occupied && (entry_q.prio <= new_entry.prio);

	always_ff @(posedge clk) begin
		priority if (ctl.pop) begin
			entry_q <= right_entry;
		end else if (ctl.push && !after) begin
			// The first cell that does not keep its entry takes the new event;
			// every cell behind it shifts one place back.
			entry_q <= left_after ? new_entry : left_entry;
		end
	end

endmodule

FILE: test/event_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Event queue checker
// Watches the item and result channels of the sorted event priority queue,
// keeps its own sorted copy of the held events, and compares every head
// report with the one it predicted for the matching item.
// ----------------------------------------------------------------------------
module event_queue_checker import spq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic                    action,
	input  logic [NODE_PORT_W-1:0]  node_id,
	input  logic [PRIO_W-1:0]       event_priority,
	input  logic [TIME_W-1:0]       event_time,
	input  logic                    event_kind,
	input  logic                    done,
	input  logic                    head_valid,
	input  logic [NODE_PORT_W-1:0]  head_node,
	input  logic [PRIO_W-1:0]       head_priority,
	input  logic [TIME_W-1:0]       head_time,
	input  logic                    head_kind,
	input  logic [OCC_W-1:0]        occupancy,
	input  logic [OUTCOME_W-1:0]    outcome,
	output int                      mismatches,
	output int                      reports_due,
	output int                      push_count,
	output int                      drop_count,
	output int                      pop_count,
	output int                      empty_pop_count,
	output int                      peak_occupancy
);

	typedef struct packed {
		logic                    valid;
		logic [NODE_PORT_W-1:0]  node;
		logic [PRIO_W-1:0]       prio;
		logic [TIME_W-1:0]       etime;
		logic                    kind;
		logic [OCC_W-1:0]        occ;
		logic [OUTCOME_W-1:0]    status;
	} head_report_t;

	entry_t       held_events[QUEUE_DEPTH];
	int           held_count;
	head_report_t head_reports_due[$];
	int           n_mismatch;
	int           n_push;
	int           n_drop;
	int           n_pop;
	int           n_empty_pop;
	int           n_peak;

	initial begin
		held_count  = 0;
		n_mismatch  = 0;
		n_push      = 0;
		n_drop      = 0;
		n_pop       = 0;
		n_empty_pop = 0;
		n_peak      = 0;
	end

	// Applies one push or pop to the held events and returns the head report.
	function automatic head_report_t apply_event_op(logic act, entry_t ev);
		head_report_t rep;
		int           pos;
		rep = '0;
		rep.status = OUT_DONE;
		if (act == ACT_POP) begin
			if (held_count == 0) begin
				rep.status = OUT_POP_EMPTY;
				n_empty_pop++;
			end else begin
				for (int i = 0; i < held_count - 1; i++)
					held_events[i] = held_events[i + 1];
				held_count--;
				n_pop++;
			end
		end else if (held_count >= QUEUE_DEPTH) begin
			rep.status = OUT_PUSH_FULL;
			n_drop++;
		end else begin
			// A new event goes behind every held event of equal or lower priority.
			pos = 0;
			while (pos < held_count && held_events[pos].prio <= ev.prio)
				pos++;
			for (int i = held_count; i > pos; i--)
				held_events[i] = held_events[i - 1];
			held_events[pos] = ev;
			held_count++;
			n_push++;
			if (held_count > n_peak)
				n_peak = held_count;
		end
		if (held_count > 0) begin
			rep.valid = 1'b1;
			rep.node  = NODE_PORT_W'(held_events[0].node);
			rep.prio  = held_events[0].prio;
			rep.etime = held_events[0].etime;
			rep.kind  = held_events[0].kind;
		end
		rep.occ = OCC_W'(held_count);
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		head_report_t got;
		head_report_t want;
		entry_t       ev;
		if (!arst_n) begin
			held_count = 0;
			head_reports_due.delete();
		end else begin
			if (start && !busy) begin
				ev.node  = node_id[STORE_NODE_W-1:0];
				ev.prio  = event_priority;
				ev.etime = event_time;
				ev.kind  = event_kind;
				head_reports_due.push_back(apply_event_op(action, ev));
			end
			if (done) begin
				got = '{head_valid, head_node, head_priority, head_time, head_kind,
					occupancy, outcome};
				if (head_reports_due.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("%0t: head report with no item waiting: valid=%0d node=%h",
							$realtime, got.valid, got.node,
							" prio=%h time=%h kind=%0d occ=%0d outcome=%0d",
							got.prio, got.etime, got.kind, got.occ, got.status);
				end else begin
					want = head_reports_due.pop_front();
					if (got !== want) begin
						n_mismatch++;
						if (n_mismatch <= 10) begin
							$display("%0t: head report mismatch", $realtime);
							$display("  expected valid=%0d node=%h prio=%h time=%h kind=%0d",
								want.valid, want.node, want.prio, want.etime, want.kind,
								" occ=%0d outcome=%0d", want.occ, want.status);
							$display("  actual   valid=%0d node=%h prio=%h time=%h kind=%0d",
								got.valid, got.node, got.prio, got.etime, got.kind,
								" occ=%0d outcome=%0d", got.occ, got.status);
						end
					end
				end
			end
		end
		mismatches      <= n_mismatch;
		reports_due     <= head_reports_due.size();
		push_count      <= n_push;
		drop_count      <= n_drop;
		pop_count       <= n_pop;
		empty_pop_count <= n_empty_pop;
		peak_occupancy  <= n_peak;
	end

endmodule

FILE: test/sorted_event_priority_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted event priority queue testbench
// Drives a short directed sequence of pushes and pops, then random runs that
// fill, drain and churn the queue with tie-heavy priorities, with random
// gaps on the item side. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module sorted_event_priority_queue_tb import spq_pkg::*;;

	localparam int RANDOM_ITEMS = 1700;
	localparam int CALM_TAIL    = 150;
	localparam int IDLE_LIMIT   = 2000;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} load_mode_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    action;
	logic [NODE_PORT_W-1:0]  node_id;
	logic [PRIO_W-1:0]       event_priority;
	logic [TIME_W-1:0]       event_time;
	logic                    event_kind;
	logic                    done;
	logic                    head_valid;
	logic [NODE_PORT_W-1:0]  head_node;
	logic [PRIO_W-1:0]       head_priority;
	logic [TIME_W-1:0]       head_time;
	logic                    head_kind;
	logic [OCC_W-1:0]        occupancy;
	logic [OUTCOME_W-1:0]    outcome;

	int mismatches;
	int reports_due;
	int push_count;
	int drop_count;
	int pop_count;
	int empty_pop_count;
	int peak_occupancy;
	int stall_cycles = 0;
	int items_sent   = 0;
	bit gaps_on      = 1'b0;

	sorted_event_priority_queue u_dut (.*);

	event_queue_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Ends the run if neither an item nor a result moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= IDLE_LIMIT) begin
			$display("sorted_event_priority_queue_tb: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_event(logic act, logic [NODE_PORT_W-1:0] node,
		logic [PRIO_W-1:0] prio, logic [TIME_W-1:0] stamp, logic kind);
		int gap;
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 17);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start          <= 1'b1;
		action         <= act;
		node_id        <= node;
		event_priority <= prio;
		event_time     <= stamp;
		event_kind     <= kind;
		do @(posedge clk); while (busy !== 1'b0);
		items_sent++;
	endtask

	// Small values and values around the middle give many equal priorities.
	function automatic logic [PRIO_W-1:0] pick_priority();
		unique case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return PRIO_W'($urandom_range(0, 7));
			5, 6: return PRIO_W'($urandom_range(16'h7FF8, 16'h8007));
			default: return PRIO_W'($urandom);
		endcase
	endfunction

	initial begin
		int         remaining;
		int         seg;
		int         pop_pct;
		load_mode_t mode;
		logic       act;
		arst_n         <= 1'b0;
		start          <= 1'b0;
		action         <= ACT_PUSH;
		node_id        <= '0;
		event_priority <= '0;
		event_time     <= '0;
		event_kind     <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		gaps_on = 1'b1;

		// Directed: empty pops, field extremes, ties at both ends of the range.
		send_event(ACT_POP, '0, '0, '0, 1'b0);
		send_event(ACT_PUSH, '1, '1, '1, 1'b1);
		send_event(ACT_PUSH, '0, '0, '0, 1'b0);
		send_event(ACT_PUSH, 14'd1, '0, 16'h0001, 1'b1);
		send_event(ACT_PUSH, 14'h2AAA, 16'h8000, 16'h5555, 1'b0);
		send_event(ACT_PUSH, 14'h1555, '1, 16'hAAAA, 1'b0);
		send_event(ACT_PUSH, 14'h0002, 16'h7FFF, 16'h1234, 1'b1);
		repeat (7) send_event(ACT_POP, '1, '1, '1, 1'b1);
		send_event(ACT_PUSH, 14'h0100, 16'h1234, 16'hFFFF, 1'b1);
		send_event(ACT_PUSH, 14'h0200, 16'h1233, 16'h0000, 1'b0);
		send_event(ACT_PUSH, 14'h0300, 16'h1234, 16'h8000, 1'b0);
		repeat (4) send_event(ACT_POP, '0, '0, '0, 1'b0);

		// Random: runs that fill the queue past full, drain it past empty, or churn.
		remaining = RANDOM_ITEMS;
		while (remaining > 0) begin
			mode = load_mode_t'($urandom_range(0, 2));
			seg = $urandom_range(20, 120);
			if (seg > remaining)
				seg = remaining;
			unique case (mode)
				MODE_FILL: pop_pct = 3;
				MODE_DRAIN: pop_pct = 90;
				default: pop_pct = 45;
			endcase
			for (int k = 0; k < seg; k++) begin
				gaps_on = (remaining - k > CALM_TAIL) && (seg % 4 != 0);
				act = ($urandom_range(0, 99) < pop_pct) ? ACT_POP : ACT_PUSH;
				send_event(act, NODE_PORT_W'($urandom), pick_priority(), TIME_W'($urandom),
					1'($urandom_range(0, 1)));
			end
			remaining -= seg;
		end
		start <= 1'b0;

		@(posedge clk);
		while (reports_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d items: %0d pushes stored, %0d dropped on a full queue,",
			items_sent, push_count, drop_count);
		$display("%0d pops served, %0d on an empty queue, peak occupancy %0d, %0d mismatches.",
			pop_count, empty_pop_count, peak_occupancy, mismatches);
		if (mismatches == 0 && reports_due == 0) begin
			$display("sorted_event_priority_queue_tb: done, clean");
		end else begin
			$display("sorted_event_priority_queue_tb: done, errors");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_event_priority_queue.sv
test/event_queue_checker.sv
test/sorted_event_priority_queue_tb.sv
